// File: hdl/plit_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise-linear interpolation table package
// Payload types, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package plit_pkg;

  typedef struct packed {
    logic               action;
    logic signed [15:0] key_in;
    logic signed [15:0] value_in;
  } cmd_data_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic               accepted;
  } rsp_data_t;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam int STEP_W    = 5;
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] S_DECODE   = 5'd1;
  localparam logic [STEP_W-1:0] S_I_CHECK  = 5'd2;
  localparam logic [STEP_W-1:0] S_I_LOOP   = 5'd3;
  localparam logic [STEP_W-1:0] S_I_CMP    = 5'd4;
  localparam logic [STEP_W-1:0] S_I_SHIFT  = 5'd5;
  localparam logic [STEP_W-1:0] S_I_PUT    = 5'd6;
  localparam logic [STEP_W-1:0] S_I_FULL   = 5'd7;
  localparam logic [STEP_W-1:0] S_Q_START  = 5'd8;
  localparam logic [STEP_W-1:0] S_Q_FIRST  = 5'd9;
  localparam logic [STEP_W-1:0] S_Q_LAST   = 5'd10;
  localparam logic [STEP_W-1:0] S_Q_SCAN   = 5'd11;
  localparam logic [STEP_W-1:0] S_Q_ADV    = 5'd12;
  localparam logic [STEP_W-1:0] S_Q_FETCH  = 5'd13;
  localparam logic [STEP_W-1:0] S_Q_BRACK  = 5'd14;
  localparam logic [STEP_W-1:0] S_Q_MUL    = 5'd15;
  localparam logic [STEP_W-1:0] S_Q_DINIT  = 5'd16;
  localparam logic [STEP_W-1:0] S_Q_DSTEP  = 5'd17;
  localparam logic [STEP_W-1:0] S_Q_RES    = 5'd18;
  localparam logic [STEP_W-1:0] S_DONE     = 5'd19;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_QUERY,
    C_FULL,
    C_EMPTY,
    C_PTR_ZERO,
    C_KEY_GE_KQ,
    C_KEY_LE_KQ,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    A_ZERO,
    A_LAST,
    A_PTR_M1,
    A_PTR_P1
  } addr_sel_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_SHIFT,
    W_NEW
  } wr_op_t;

  typedef enum logic [2:0] {
    P_HOLD,
    P_LOAD,
    P_CLEAR,
    P_INC,
    P_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    R_HOLD,
    R_ZERO,
    R_VQ,
    R_DIV
  } res_op_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_SET,
    K_CLR
  } acc_op_t;

  typedef enum logic [3:0] {
    X_NONE,
    X_LD_IN,
    X_LD_A0,
    X_LD_A1,
    X_MUL,
    X_DIV_INIT,
    X_DIV_STEP,
    X_CNT_INC,
    X_EMIT
  } xop_t;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              fin;
    addr_sel_t         addr;
    wr_op_t            wr;
    ptr_op_t           ptr;
    res_op_t           res;
    acc_op_t           acc;
    xop_t              xop;
  } ctrl_t;

  typedef struct packed {
    logic query;
    logic full;
    logic empty;
    logic ptr_zero;
    logic key_ge_kq;
    logic key_le_kq;
    logic div_more;
    logic out_busy;
  } flags_t;

  localparam ctrl_t CTRL_NOP = '{
    cond: C_NEVER, target: S_IDLE, fin: 1'b0, addr: A_ZERO, wr: W_NONE,
    ptr: P_HOLD, res: R_HOLD, acc: K_HOLD, xop: X_NONE
  };

  function automatic ctrl_t plit_ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = CTRL_NOP;
    case (step)
      S_IDLE: begin
        c.cond = C_NO_INPUT; c.target = S_IDLE; c.xop = X_LD_IN;
      end
      S_DECODE: begin
        c.cond = C_QUERY; c.target = S_Q_START; c.res = R_ZERO; c.ptr = P_LOAD;
      end
      S_I_CHECK: begin
        c.cond = C_FULL; c.target = S_I_FULL;
      end
      S_I_LOOP: begin
        c.cond = C_PTR_ZERO; c.target = S_I_PUT; c.addr = A_PTR_M1;
      end
      S_I_CMP: begin
        c.cond = C_KEY_GE_KQ; c.target = S_I_PUT; c.addr = A_PTR_M1;
      end
      S_I_SHIFT: begin
        c.cond = C_ALWAYS; c.target = S_I_LOOP; c.addr = A_PTR_M1;
        c.wr = W_SHIFT; c.ptr = P_DEC;
      end
      S_I_PUT: begin
        c.cond = C_ALWAYS; c.target = S_DONE; c.wr = W_NEW; c.acc = K_SET;
        c.xop = X_CNT_INC;
      end
      S_I_FULL: begin
        c.cond = C_ALWAYS; c.target = S_DONE; c.acc = K_CLR;
      end
      S_Q_START: begin
        c.cond = C_EMPTY; c.target = S_DONE; c.acc = K_SET; c.addr = A_ZERO;
      end
      S_Q_FIRST: begin
        c.cond = C_KEY_LE_KQ; c.target = S_DONE; c.addr = A_LAST; c.res = R_VQ;
        c.ptr = P_CLEAR; c.xop = X_LD_A0;
      end
      S_Q_LAST: begin
        c.cond = C_KEY_GE_KQ; c.target = S_DONE; c.addr = A_PTR_P1; c.res = R_VQ;
      end
      S_Q_SCAN: begin
        c.cond = C_KEY_LE_KQ; c.target = S_Q_BRACK; c.addr = A_PTR_P1;
      end
      S_Q_ADV: begin
        c.addr = A_PTR_P1; c.ptr = P_INC; c.xop = X_LD_A0;
      end
      S_Q_FETCH: begin
        c.cond = C_ALWAYS; c.target = S_Q_SCAN; c.addr = A_PTR_P1;
      end
      S_Q_BRACK: begin
        c.xop = X_LD_A1;
      end
      S_Q_MUL: begin
        c.xop = X_MUL;
      end
      S_Q_DINIT: begin
        c.xop = X_DIV_INIT;
      end
      S_Q_DSTEP: begin
        c.cond = C_DIV_MORE; c.target = S_Q_DSTEP; c.xop = X_DIV_STEP;
      end
      S_Q_RES: begin
        c.res = R_DIV;
      end
      S_DONE: begin
        c.cond = C_OUT_BUSY; c.target = S_DONE; c.fin = 1'b1; c.xop = X_EMIT;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// File: hdl/plit_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one payload per transaction between a source and a sink.
// ----------------------------------------------------------------------------
interface plit_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/plit_useq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the program table with conditional jumps.
// ----------------------------------------------------------------------------
module plit_useq (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  plit_pkg::flags_t flags,
  output plit_pkg::ctrl_t  ctrl,
  output logic             ready
);
  import plit_pkg::*;

  logic [STEP_W-1:0] upc;
  logic [STEP_W-1:0] upc_next;
  logic              taken;

  assign ctrl  = plit_ucode(upc);
  assign ready = (upc == S_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_INPUT:  taken = !cmd_valid;
      C_QUERY:     taken = flags.query;
      C_FULL:      taken = flags.full;
      C_EMPTY:     taken = flags.empty;
      C_PTR_ZERO:  taken = flags.ptr_zero;
      C_KEY_GE_KQ: taken = flags.key_ge_kq;
      C_KEY_LE_KQ: taken = flags.key_le_kq;
      C_DIV_MORE:  taken = flags.div_more;
      C_OUT_BUSY:  taken = flags.out_busy;
      default:     taken = 1'b0;
    endcase
    if (taken) begin
      upc_next = ctrl.target;
    end else if (ctrl.fin) begin
      upc_next = S_IDLE;
    end else begin
      upc_next = upc + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  a_upc_range: assert property (@(posedge clk) disable iff (rst) upc <= S_DONE)
    else $error("Step counter left the program.");

  a_done_exit: assert property (@(posedge clk) disable iff (rst)
    (upc == S_DONE && !flags.out_busy) |=> (upc == S_IDLE))
    else $error("Sequencer did not return to idle after the result.");

  a_idle_wait: assert property (@(posedge clk) disable iff (rst)
    (upc == S_IDLE && !cmd_valid) |=> (upc == S_IDLE))
    else $error("Sequencer left idle without a transaction.");

endmodule

// File: hdl/plit_datapath.sv
// ----------------------------------------------------------------------------
// Table datapath
// Breakpoint memories, bracket registers, multiplier and serial divider.
// ----------------------------------------------------------------------------
module plit_datapath #(
  parameter int MAX_ENTRIES = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  plit_pkg::ctrl_t    ctrl,
  input  plit_pkg::cmd_data_t cmd_data,
  output plit_pkg::flags_t   flags,
  plit_stream_if.source      rsp
);
  import plit_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic signed [15:0] key_mem [MAX_ENTRIES];
  logic signed [15:0] val_mem [MAX_ENTRIES];

  logic [CW-1:0]      count;
  logic [AW-1:0]      ptr;
  logic [AW-1:0]      raddr;
  logic signed [15:0] kq;
  logic signed [15:0] vq;

  logic               action;
  logic signed [15:0] key;
  logic signed [15:0] value;
  logic signed [15:0] a0;
  logic signed [15:0] p0;
  logic signed [15:0] a1;
  logic signed [15:0] p1;
  logic signed [33:0] prod;
  logic [15:0]        span;
  logic [15:0]        rem;
  logic [15:0]        qsh;
  logic               neg;
  logic [DCNT_W-1:0]  dcnt;
  logic signed [15:0] res;
  logic               acc;

  logic signed [16:0] dp;
  logic signed [16:0] dx;
  logic signed [16:0] sp;
  logic signed [33:0] mag;
  logic [16:0]        trial;
  logic               trial_ge;
  logic signed [16:0] qs;
  logic signed [16:0] sum;
  logic               emit;

  always_comb begin
    case (ctrl.addr)
      A_ZERO:   raddr = '0;
      A_LAST:   raddr = AW'(count - CW'(1));
      A_PTR_M1: raddr = ptr - AW'(1);
      A_PTR_P1: raddr = ptr + AW'(1);
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr == W_NEW) begin
      key_mem[ptr] <= key;
      val_mem[ptr] <= value;
    end else if (ctrl.wr == W_SHIFT) begin
      key_mem[ptr] <= kq;
      val_mem[ptr] <= vq;
    end
    kq <= key_mem[raddr];
    vq <= val_mem[raddr];
  end

  assign dp       = 17'(p1) - 17'(p0);
  assign dx       = 17'(key) - 17'(a0);
  assign sp       = 17'(a1) - 17'(a0);
  assign mag      = prod[33] ? -prod : prod;
  assign trial    = {rem, qsh[15]};
  assign trial_ge = (trial >= {1'b0, span});
  assign qs       = $signed({1'b0, qsh});
  assign sum      = 17'(p0) + (neg ? -qs : qs);
  assign emit     = (ctrl.xop == X_EMIT) && !flags.out_busy;

  always_ff @(posedge clk) begin
    case (ctrl.xop)
      X_LD_IN: begin
        action <= cmd_data.action;
        key    <= cmd_data.key_in;
        value  <= cmd_data.value_in;
      end
      X_LD_A0: begin
        a0 <= kq;
        p0 <= vq;
      end
      X_LD_A1: begin
        a1 <= kq;
        p1 <= vq;
      end
      X_MUL: begin
        prod <= dp * dx;
        span <= sp[15:0];
      end
      X_DIV_INIT: begin
        neg <= prod[33];
        rem <= mag[31:16];
        qsh <= mag[15:0];
      end
      X_DIV_STEP: begin
        rem <= trial_ge ? 16'(trial - {1'b0, span}) : trial[15:0];
        qsh <= {qsh[14:0], trial_ge};
      end
      default: begin
      end
    endcase

    case (ctrl.res)
      R_ZERO:  res <= '0;
      R_VQ:    res <= vq;
      R_DIV:   res <= sum[15:0];
      default: res <= res;
    endcase

    case (ctrl.acc)
      K_SET:   acc <= 1'b1;
      K_CLR:   acc <= 1'b0;
      default: acc <= acc;
    endcase

    if (emit) begin
      rsp.data.result_value <= res;
      rsp.data.accepted     <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      dcnt      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (ctrl.xop == X_CNT_INC) begin
        count <= count + CW'(1);
      end
      case (ctrl.ptr)
        P_LOAD:  ptr <= AW'(count);
        P_CLEAR: ptr <= '0;
        P_INC:   ptr <= ptr + AW'(1);
        P_DEC:   ptr <= ptr - AW'(1);
        default: ptr <= ptr;
      endcase
      if (ctrl.xop == X_DIV_INIT) begin
        dcnt <= DCNT_W'(DIV_STEPS);
      end else if (ctrl.xop == X_DIV_STEP) begin
        dcnt <= dcnt - DCNT_W'(1);
      end
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_comb begin
    flags.query     = (action == ACT_QUERY);
    flags.full      = (count == CW'(MAX_ENTRIES));
    flags.empty     = (count == '0);
    flags.ptr_zero  = (ptr == '0);
    flags.key_ge_kq = (key >= kq);
    flags.key_le_kq = (key <= kq);
    flags.div_more  = (dcnt != DCNT_W'(1));
    flags.out_busy  = rsp.valid && !rsp.ready;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("Entry count exceeds the table depth.");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wr == W_NEW) |-> (count < CW'(MAX_ENTRIES)))
    else $error("Breakpoint written into a full table.");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (ctrl.xop == X_DIV_STEP) |-> (rem < span))
    else $error("Divider remainder is not below the divisor.");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> rsp.valid)
    else $error("Result was not presented after it was produced.");

endmodule

// File: hdl/piecewise_linear_interp_table.sv
// ----------------------------------------------------------------------------
// Piecewise-linear interpolation table
// Sorted breakpoint table with insert and interpolating lookup in Q8.8.
// ----------------------------------------------------------------------------
// Each cmd transaction carries an action, a key and a value; each one yields
// exactly one rsp transaction. An insert stores the breakpoint after all
// entries with a key less than or equal to it and reports accepted = 0 when
// the table is full. A query returns the value interpolated between the two
// bracketing breakpoints, clamped to the first or last value outside the key
// range, and zero when the table is empty.
// The block works on one transaction at a time under a microcode program.
// An insert's length is set by the shift through the breakpoint memories,
// which have one registered read port: it passes a check, a compare and a
// shift step for each entry moved. A query's length is set by the bracket
// scan and the 16-step divider.
// cmd is ready again in the cycle after the result is registered, so a new
// transaction is taken while the previous result still waits on rsp.
// A stalled rsp holds its result and the sequencer waits before loading the
// next one. Reset empties the table at once, with no clearing pass.
// ----------------------------------------------------------------------------
module piecewise_linear_interp_table #(
  parameter int MAX_ENTRIES = 10
) (
  input logic           clk,
  input logic           rst,
  plit_stream_if.sink   cmd,
  plit_stream_if.source rsp
);
  import plit_pkg::*;

  ctrl_t     ctrl;
  flags_t    flags;
  logic      ready;
  cmd_data_t cmd_data;

  assign cmd.ready = ready;
  assign cmd_data  = cmd.data;

  plit_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .flags     (flags),
    .ctrl      (ctrl),
    .ready     (ready)
  );

  plit_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cmd_data (cmd_data),
    .flags    (flags),
    .rsp      (rsp)
  );

endmodule
